>>> hdl/prqd_pkg.sv
// Package for the priority ready queue dispatcher: constants, transaction types and helpers.
`timescale 1ns / 1ps

package prqd_pkg;

    // Queue capacity and priority width.
    localparam int QUEUE_DEPTH = 64;
    localparam int PRIO_BITS   = 3;
    localparam int SLOT_W      = 6;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = SLOT_W + PRIO_BITS;

    // Command codes.
    localparam logic CMD_READY    = 1'b0;
    localparam logic CMD_DISPATCH = 1'b1;

    // Running process states reported with a dispatch.
    localparam logic [1:0] RUN_RUNNABLE = 2'd0;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [5:0] proc_slot;
        logic [2:0] prio;
        logic [1:0] run_state;
    } t_in_item;

    typedef struct packed {
        logic       switched;
        logic       run_valid;
        logic [5:0] run_slot;
        logic [5:0] prev_slot;
        logic [1:0] status_code;
    } t_out_item;

    // One queue entry as held in the memory.
    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CMP,
        S_INS_RD,
        S_INS_CMP,
        S_OUT
    } t_state;

    // Physical address of the entry k places behind the head of the circular queue.
    function automatic logic [ADDR_W-1:0] f_phys(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  k);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(k);
        if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

>>> hdl/prqd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module prqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/priority_ready_queue_dispatcher.sv
// Top level of the priority ready queue dispatcher: sequencer, queue memory and running process.
`timescale 1ns / 1ps

// The dispatcher keeps a ready queue of process slots ordered by priority (a lower number is
// more urgent, first come first served within a priority) together with the one running
// process. A ready transaction (cmd 0) inserts a slot behind every entry of equal or more
// urgent priority, or reports status 1 when the queue is full. A dispatch transaction (cmd 1)
// carries the running process's state and produces the decision: the queue head is taken when
// nothing runs, when the head is strictly more urgent (a runnable process is then put back), or
// when the running process is blocked or quitting; status 2 flags an empty queue when a process
// was needed. Every input transaction gives exactly one result transaction. The block handles
// one transaction at a time. The queue lives in a circular memory with a head pointer, so taking
// the head is a pointer step, while an insert walks back from the tail one entry at a time,
// moving each less urgent entry up by one place through the memory's single read and write
// ports. A transaction that touches no queue entry goes straight to its result, a dispatch
// reads and checks the head first, and an insert reads and compares one entry at a time until
// the new entry's place is found or the walk reaches the head of the queue; a preemption does
// the head check before its insert. The block is ready again in the cycle after the result is
// taken. The memory needs no clearing after reset: only entries below the fill count are ever
// read.
module priority_ready_queue_dispatcher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  prqd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output prqd_pkg::t_out_item  o_out_data
);

    // Sequencer state.
    prqd_pkg::t_state r_state, n_state;

    // Queue bookkeeping: head pointer, fill count and the insert walk index.
    logic [prqd_pkg::ADDR_W-1:0]    r_head, n_head;
    logic [prqd_pkg::CNT_W-1:0]     r_count, n_count;
    logic [prqd_pkg::CNT_W-1:0]     r_k, n_k;

    // Entry being inserted.
    logic [prqd_pkg::SLOT_W-1:0]    r_ins_slot, n_ins_slot;
    logic [prqd_pkg::PRIO_BITS-1:0] r_ins_prio, n_ins_prio;

    // Running process.
    logic                           r_run_valid, n_run_valid;
    logic [prqd_pkg::SLOT_W-1:0]    r_run_slot, n_run_slot;
    logic [prqd_pkg::PRIO_BITS-1:0] r_run_prio, n_run_prio;
    logic                           r_runnable, n_runnable;

    // Result fields gathered during the transaction.
    logic                           r_switched, n_switched;
    logic [prqd_pkg::SLOT_W-1:0]    r_prev, n_prev;
    logic [1:0]                     r_status, n_status;

    // Memory ports.
    logic                           ram_we;
    logic [prqd_pkg::ADDR_W-1:0]    ram_waddr;
    logic [prqd_pkg::ADDR_W-1:0]    ram_raddr;
    prqd_pkg::t_entry               ram_wdata;
    prqd_pkg::t_entry               rd_entry;
    logic [prqd_pkg::ENTRY_W-1:0]   ram_rdata;

    logic                           in_accept;
    logic [prqd_pkg::CNT_W-1:0]     k_prev;
    logic [prqd_pkg::ADDR_W-1:0]    addr_k;
    logic [prqd_pkg::ADDR_W-1:0]    addr_k_prev;
    logic [prqd_pkg::ADDR_W-1:0]    head_next;

    // The one priority comparator, shared between the head check and the insert walk.
    logic [prqd_pkg::PRIO_BITS-1:0] cmp_a, cmp_b;
    logic                           cmp_lt;
    logic                           take_head;

    assign in_accept = i_in_valid && o_in_ready;
    assign rd_entry  = prqd_pkg::t_entry'(ram_rdata);

    assign k_prev      = (r_k == '0) ? '0 : r_k - prqd_pkg::CNT_W'(1);
    assign addr_k      = prqd_pkg::f_phys(r_head, r_k);
    assign addr_k_prev = prqd_pkg::f_phys(r_head, k_prev);
    assign head_next   = prqd_pkg::f_phys(r_head, prqd_pkg::CNT_W'(1));

    // At the head check the question is whether the head beats the running process; during the
    // insert walk it is whether the new entry beats the entry just read, in which case that
    // entry moves up one place.
    always_comb begin
        if (r_state == prqd_pkg::S_HEAD_CMP) begin
            cmp_a = rd_entry.prio;
            cmp_b = r_run_prio;
        end else begin
            cmp_a = r_ins_prio;
            cmp_b = rd_entry.prio;
        end
    end

    assign cmp_lt    = cmp_a < cmp_b;
    assign take_head = !r_run_valid || cmp_lt || !r_runnable;

    prqd_ram #(
        .WIDTH (prqd_pkg::ENTRY_W),
        .DEPTH (prqd_pkg::QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prqd_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_in_data.cmd == prqd_pkg::CMD_READY) begin
                        if (r_count == prqd_pkg::CNT_W'(prqd_pkg::QUEUE_DEPTH)) begin
                            n_state = prqd_pkg::S_OUT;
                        end else begin
                            n_state = prqd_pkg::S_INS_RD;
                        end
                    end else if (r_count == '0) begin
                        n_state = prqd_pkg::S_OUT;
                    end else begin
                        n_state = prqd_pkg::S_HEAD_RD;
                    end
                end
            end
            prqd_pkg::S_HEAD_RD: begin
                n_state = prqd_pkg::S_HEAD_CMP;
            end
            prqd_pkg::S_HEAD_CMP: begin
                // A preempted process that is still runnable goes back into the queue.
                if (take_head && r_run_valid && r_runnable) begin
                    n_state = prqd_pkg::S_INS_RD;
                end else begin
                    n_state = prqd_pkg::S_OUT;
                end
            end
            prqd_pkg::S_INS_RD: begin
                if (r_k == '0) begin
                    n_state = prqd_pkg::S_OUT;
                end else begin
                    n_state = prqd_pkg::S_INS_CMP;
                end
            end
            prqd_pkg::S_INS_CMP: begin
                if (cmp_lt) begin
                    n_state = prqd_pkg::S_INS_RD;
                end else begin
                    n_state = prqd_pkg::S_OUT;
                end
            end
            prqd_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = prqd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = prqd_pkg::S_IDLE;
            end
        endcase
    end

    // Handshake and memory control.
    always_comb begin
        o_in_ready  = (r_state == prqd_pkg::S_IDLE);
        o_out_valid = (r_state == prqd_pkg::S_OUT);
        ram_raddr   = (r_state == prqd_pkg::S_HEAD_RD) ? r_head : addr_k_prev;
        ram_waddr   = addr_k;
        ram_we      = 1'b0;
        ram_wdata   = '{slot: r_ins_slot, prio: r_ins_prio};
        case (r_state)
            prqd_pkg::S_INS_RD: begin
                // Reached the head end of the queue: the new entry goes first.
                ram_we = (r_k == '0);
            end
            prqd_pkg::S_INS_CMP: begin
                ram_we = 1'b1;
                if (cmp_lt) begin
                    ram_wdata = rd_entry;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next values of the queue, running process and result registers.
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_k         = r_k;
        n_ins_slot  = r_ins_slot;
        n_ins_prio  = r_ins_prio;
        n_run_valid = r_run_valid;
        n_run_slot  = r_run_slot;
        n_run_prio  = r_run_prio;
        n_runnable  = r_runnable;
        n_switched  = r_switched;
        n_prev      = r_prev;
        n_status    = r_status;
        case (r_state)
            prqd_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_switched = 1'b0;
                    n_prev     = '0;
                    n_status   = prqd_pkg::STATUS_OK;
                    n_ins_slot = i_in_data.proc_slot;
                    n_ins_prio = i_in_data.prio[prqd_pkg::PRIO_BITS-1:0];
                    n_k        = r_count;
                    // Any state other than runnable, the unused code included, counts as blocked.
                    n_runnable = (i_in_data.run_state == prqd_pkg::RUN_RUNNABLE);
                    if (i_in_data.cmd == prqd_pkg::CMD_READY) begin
                        if (r_count == prqd_pkg::CNT_W'(prqd_pkg::QUEUE_DEPTH)) begin
                            n_status = prqd_pkg::STATUS_FULL;
                        end
                    end else if (r_count == '0) begin
                        if (!r_run_valid) begin
                            n_status = prqd_pkg::STATUS_EMPTY;
                        end else if (i_in_data.run_state != prqd_pkg::RUN_RUNNABLE) begin
                            // The running process stops and nothing can replace it.
                            n_run_valid = 1'b0;
                            n_run_slot  = '0;
                            n_run_prio  = '0;
                            n_prev      = r_run_slot;
                            n_status    = prqd_pkg::STATUS_EMPTY;
                        end
                    end
                end
            end
            prqd_pkg::S_HEAD_CMP: begin
                if (take_head) begin
                    n_run_valid = 1'b1;
                    n_run_slot  = rd_entry.slot;
                    n_run_prio  = rd_entry.prio;
                    n_head      = head_next;
                    n_count     = r_count - prqd_pkg::CNT_W'(1);
                    n_switched  = 1'b1;
                    n_prev      = r_run_valid ? r_run_slot : '0;
                    // Prepared for putting the old process back, used only when it is runnable.
                    n_ins_slot  = r_run_slot;
                    n_ins_prio  = r_run_prio;
                    n_k         = r_count - prqd_pkg::CNT_W'(1);
                end
            end
            prqd_pkg::S_INS_RD: begin
                if (r_k == '0) begin
                    n_count = r_count + prqd_pkg::CNT_W'(1);
                end
            end
            prqd_pkg::S_INS_CMP: begin
                if (cmp_lt) begin
                    n_k = k_prev;
                end else begin
                    n_count = r_count + prqd_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_head = r_head;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prqd_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_run_valid <= 1'b0;
            r_run_slot  <= '0;
            r_run_prio  <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_run_valid <= n_run_valid;
            r_run_slot  <= n_run_slot;
            r_run_prio  <= n_run_prio;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_ins_slot <= n_ins_slot;
        r_ins_prio <= n_ins_prio;
        r_runnable <= n_runnable;
        r_switched <= n_switched;
        r_prev     <= n_prev;
        r_status   <= n_status;
    end

    // The result is held in registers for as long as the output transaction waits.
    always_comb begin
        o_out_data.switched    = r_switched;
        o_out_data.run_valid   = r_run_valid;
        o_out_data.run_slot    = r_run_valid ? r_run_slot : '0;
        o_out_data.prev_slot   = r_prev;
        o_out_data.status_code = r_status;
    end

endmodule

>>> test/tb_priority_ready_queue_dispatcher.sv
// Self-checking testbench for the priority ready queue dispatcher, with its own decision predictor.
`timescale 1ns / 1ps

// Stimulus is built by the initial block as a queue of pending input transactions, phase by
// phase. A clocked driver offers them on the falling edge, and a clocked receiver sets the
// output ready there too. The monitor samples both handshakes on the rising edge. Each
// accepted input transaction is run through a predictor of the ready queue and the running
// process. The decision that comes out is held in order until the matching result
// transaction arrives, and is then compared field by field.
module tb_priority_ready_queue_dispatcher;

    // Running process states other than runnable. Value three is unused and acts as blocked.
    localparam logic [1:0] RUN_BLOCKED  = 2'd1;
    localparam logic [1:0] RUN_QUITTING = 2'd2;
    localparam logic [1:0] RUN_UNUSED   = 2'd3;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int MAX_WAIT      = 13;
    // The long receiver stall. The block takes one transaction at a time, so it backs up
    // almost at once.
    localparam int HOLD_CYCLES   = 300;
    // The slowest transaction is a preemption that moves the whole queue. The hold above
    // dominates, and the limit leaves a wide margin.
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 2 * prqd_pkg::QUEUE_DEPTH + 20;
    localparam int PHASE_ITEMS   = 250;

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    prqd_pkg::t_in_item  in_data   = '0;
    logic                out_ready = 1'b1;
    logic                in_ready;
    logic                out_valid;
    prqd_pkg::t_out_item out_data;

    priority_ready_queue_dispatcher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Pending input transactions, and decisions waiting for their result transaction.
    prqd_pkg::t_in_item  pending_cmds [$];
    prqd_pkg::t_out_item decision_q   [$];

    // Handshake events seen at the rising edge and consumed at the next falling edge.
    bit in_taken    = 1'b0;
    bit out_taken   = 1'b0;
    bit tx_idle_en  = 1'b0;
    bit rx_idle_en  = 1'b0;
    bit rx_hold_req = 1'b0;
    int tx_gap      = 0;
    int rx_wait     = 0;
    int idle_cycles = 0;
    int mismatches  = 0;

    // Predictor state: the ready queue with its head at index 0, and the running process.
    logic [prqd_pkg::SLOT_W-1:0]    ready_slot [prqd_pkg::QUEUE_DEPTH];
    logic [prqd_pkg::PRIO_BITS-1:0] ready_prio [prqd_pkg::QUEUE_DEPTH];
    int                             ready_count = 0;
    logic [prqd_pkg::SLOT_W-1:0]    cur_slot    = '0;
    logic [prqd_pkg::PRIO_BITS-1:0] cur_prio    = '0;
    logic                           cur_valid   = 1'b0;

    // A new entry goes behind every entry of equal or more urgent priority.
    function automatic void insert_ready(logic [prqd_pkg::SLOT_W-1:0]    slot,
                                         logic [prqd_pkg::PRIO_BITS-1:0] prio);
        int pos;
        pos = 0;
        while (pos < ready_count && ready_prio[pos] <= prio) begin
            pos++;
        end
        for (int k = ready_count; k > pos; k--) begin
            ready_slot[k] = ready_slot[k-1];
            ready_prio[k] = ready_prio[k-1];
        end
        ready_slot[pos] = slot;
        ready_prio[pos] = prio;
        ready_count++;
    endfunction

    function automatic void promote_head();
        cur_slot  = ready_slot[0];
        cur_prio  = ready_prio[0];
        cur_valid = 1'b1;
        for (int k = 1; k < ready_count; k++) begin
            ready_slot[k-1] = ready_slot[k];
            ready_prio[k-1] = ready_prio[k];
        end
        ready_count--;
    endfunction

    function automatic prqd_pkg::t_out_item dispatch_decision(prqd_pkg::t_in_item item);
        prqd_pkg::t_out_item            d;
        logic                           runnable;
        logic [prqd_pkg::SLOT_W-1:0]    old_slot;
        logic [prqd_pkg::PRIO_BITS-1:0] old_prio;
        d        = '0;
        runnable = (item.run_state == prqd_pkg::RUN_RUNNABLE);
        old_slot = cur_slot;
        old_prio = cur_prio;
        if (item.cmd == prqd_pkg::CMD_READY) begin
            if (ready_count >= prqd_pkg::QUEUE_DEPTH) begin
                d.status_code = prqd_pkg::STATUS_FULL;
            end else begin
                insert_ready(item.proc_slot, item.prio);
            end
        end else if (!cur_valid) begin
            if (ready_count == 0) begin
                d.status_code = prqd_pkg::STATUS_EMPTY;
            end else begin
                promote_head();
                d.switched = 1'b1;
            end
        end else if (ready_count == 0) begin
            // A runnable process just carries on; any other state stops it with nobody to follow.
            if (!runnable) begin
                cur_valid     = 1'b0;
                cur_slot      = '0;
                cur_prio      = '0;
                d.prev_slot   = old_slot;
                d.status_code = prqd_pkg::STATUS_EMPTY;
            end
        end else if (ready_prio[0] < old_prio) begin
            // Preemption: the head is taken first, so putting the old process back always fits.
            promote_head();
            if (runnable) begin
                insert_ready(old_slot, old_prio);
            end
            d.switched  = 1'b1;
            d.prev_slot = old_slot;
        end else if (!runnable) begin
            promote_head();
            d.switched  = 1'b1;
            d.prev_slot = old_slot;
        end
        d.run_valid = cur_valid;
        d.run_slot  = cur_valid ? cur_slot : '0;
        return d;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: the next transaction is loaded once the previous one has been accepted and the
    // gap drawn for it has run out. Valid is written once per falling edge, so a back-to-back
    // transaction keeps valid high and only the payload changes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_taken || !in_valid) begin
            in_taken = 1'b0;
            if (tx_gap > 0) begin
                in_valid <= 1'b0;
                tx_gap--;
            end else if (pending_cmds.size() != 0) begin
                in_data  <= pending_cmds.pop_front();
                in_valid <= 1'b1;
                tx_gap   = tx_idle_en ? $urandom_range(MAX_WAIT, 0) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a fresh stall is drawn after each result transaction. A hold request overrides
    // this with one long stretch, and the receiver counts that stretch down itself.
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            rx_wait   = rx_idle_en ? $urandom_range(MAX_WAIT, 0) : 0;
        end
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_wait     = HOLD_CYCLES;
        end
        if (rx_wait > 0) begin
            out_ready <= 1'b0;
            rx_wait--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor. The result is checked before the input of the same edge is predicted. A result
    // therefore never matches a decision that was made at the same edge.
    always @(posedge i_clk) begin
        prqd_pkg::t_out_item want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                out_taken = 1'b1;
                if (decision_q.size() == 0) begin
                    $error("result transaction with no decision pending");
                    mismatches++;
                end else begin
                    want = decision_q.pop_front();
                    check_field("switched",    want.switched,    out_data.switched);
                    check_field("run_valid",   want.run_valid,   out_data.run_valid);
                    check_field("run_slot",    want.run_slot,    out_data.run_slot);
                    check_field("prev_slot",   want.prev_slot,   out_data.prev_slot);
                    check_field("status_code", want.status_code, out_data.status_code);
                end
            end
            if (in_valid && in_ready) begin
                in_taken = 1'b1;
                decision_q.push_back(dispatch_decision(in_data));
            end
            if ((out_valid && out_ready) || (in_valid && in_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // Don't-care fields are randomised as well, so that every input bit toggles.
    task automatic queue_ready(input logic [prqd_pkg::SLOT_W-1:0]    slot,
                               input logic [prqd_pkg::PRIO_BITS-1:0] prio);
        prqd_pkg::t_in_item item;
        item.cmd       = prqd_pkg::CMD_READY;
        item.proc_slot = slot;
        item.prio      = prio;
        item.run_state = 2'($urandom_range(3, 0));
        pending_cmds.push_back(item);
    endtask

    task automatic queue_dispatch(input logic [1:0] state);
        prqd_pkg::t_in_item item;
        item.cmd       = prqd_pkg::CMD_DISPATCH;
        item.proc_slot = 6'($urandom);
        item.prio      = 3'($urandom);
        item.run_state = state;
        pending_cmds.push_back(item);
    endtask

    // The sender stops here until every pending transaction has produced its result.
    task automatic wait_all_retired();
        while (pending_cmds.size() != 0 || in_valid || decision_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int ready_pct [8];
        ready_pct = '{70, 50, 85, 30, 90, 15, 55, 40};

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk through the decision rules. The annotations give the state after
        // each transaction.
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // nothing runs and the queue is empty
        queue_ready(6'd0, 3'd7);
        queue_ready(6'd63, 3'd0);
        queue_ready(6'd42, 3'd0);       // same priority as 63, so it queues behind it
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // idle processor takes 63
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // equal priority head, no switch
        queue_dispatch(RUN_BLOCKED);    // 63 blocks, 42 takes over
        queue_ready(6'd21, 3'd3);
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // less urgent head, 42 keeps running
        queue_dispatch(RUN_QUITTING);   // 42 quits, 21 takes over
        queue_ready(6'd9, 3'd1);
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // 9 preempts 21, and 21 goes back
        queue_ready(6'd30, 3'd3);       // goes behind 21
        queue_dispatch(RUN_UNUSED);     // treated as blocked: 21 runs, 9 is dropped
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // 30 has equal priority, no switch
        queue_dispatch(RUN_QUITTING);   // 30 runs
        queue_dispatch(RUN_BLOCKED);    // a less urgent head still replaces a blocked process
        queue_dispatch(prqd_pkg::RUN_RUNNABLE);   // empty queue, slot 0 keeps running
        queue_dispatch(RUN_QUITTING);   // empty queue, slot 0 stops
        queue_dispatch(RUN_BLOCKED);    // nothing runs and the queue is empty
        wait_all_retired();

        // Fill past capacity while the receiver stalls for a long stretch. The sender keeps
        // offering transactions, so the block backs up. Then drain with dispatches.
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b1;
        rx_hold_req = 1'b1;
        for (int n = 0; n < prqd_pkg::QUEUE_DEPTH + 2; n++) begin
            queue_ready(6'($urandom), 3'($urandom));
        end
        for (int n = 0; n < 70; n++) begin
            queue_dispatch(2'($urandom_range(3, 0)));
        end
        wait_all_retired();

        // Random phases. The ready share varies, so the queue swings between full and empty.
        // Every third phase runs without idling.
        for (int p = 0; p < 8; p++) begin
            tx_idle_en = (p % 3 != 0);
            rx_idle_en = (p % 3 != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99, 0) < ready_pct[p]) begin
                    queue_ready(6'($urandom), 3'($urandom));
                end else begin
                    queue_dispatch(2'($urandom_range(3, 0)));
                end
            end
            wait_all_retired();
        end

        // Give any stray result time to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/prqd_pkg.sv
hdl/prqd_ram.sv
hdl/priority_ready_queue_dispatcher.sv
test/tb_priority_ready_queue_dispatcher.sv
